// ===== rtl/dctd_pkg.sv =====
// ----------------------------------------------------------------------------
// dctd_pkg: shared types and constants for the divisor counter
// Sizes of the sieve and prime table, state encoding.
// ----------------------------------------------------------------------------
package dctd_pkg;

  localparam int PRIME_LIMIT = 65536;
  localparam int PRIME_SLOTS = 6542;
  localparam int MARK_AW     = $clog2(PRIME_LIMIT);
  localparam int SLOT_AW     = $clog2(PRIME_SLOTS);
  localparam int FOUND_W     = $clog2(PRIME_SLOTS + 1);
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 11;
  localparam int EXP_W       = 6;
  localparam int PRIME_W     = MARK_AW;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MARK,
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_NEXT,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/dctd_divider.sv =====
// ----------------------------------------------------------------------------
// dctd_divider: radix-2 restoring divider
// 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dctd_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [dctd_pkg::VALUE_W-1:0] dividend,
  input  logic [dctd_pkg::PRIME_W-1:0] divisor,
  output logic                     done,
  output logic [dctd_pkg::VALUE_W-1:0] quotient,
  output logic                     rem_zero
);
  import dctd_pkg::*;

  logic               busy;
  logic [VALUE_W-1:0] quo;
  logic [PRIME_W:0]   rem;
  logic [PRIME_W-1:0] dsr;
  logic [5:0]         cnt;
  logic [PRIME_W:0]   trial;
  logic [PRIME_W:0]   diff;

  assign trial = {rem[PRIME_W-1:0], quo[VALUE_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(VALUE_W);
        quo  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= diff;
          quo <= {quo[VALUE_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[VALUE_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign rem_zero = (rem == '0);

endmodule

// ===== rtl/dctd_mul.sv =====
// ----------------------------------------------------------------------------
// dctd_mul: divisor count accumulator
// Registered multiply of the running count by (exponent + 1); init sets it to one, dbl doubles it.
// ----------------------------------------------------------------------------
module dctd_mul (
  input  logic                          clk,
  input  logic                          init,
  input  logic                          acc,
  input  logic                          dbl,
  input  logic [dctd_pkg::EXP_W-1:0]    exponent,
  output logic [dctd_pkg::COUNT_W-1:0]  count
);
  import dctd_pkg::*;

  logic [COUNT_W+EXP_W:0] prod;

  assign prod = count * (EXP_W'(exponent) + 7'd1);

  always_ff @(posedge clk) begin
    if (init) begin
      count <= COUNT_W'(1);
    end else if (acc) begin
      count <= prod[COUNT_W-1:0];
    end else if (dbl) begin
      count <= {count[COUNT_W-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/divisor_count_trial_division.sv =====
// Divisor counter by trial division over a sieved prime table.
// After reset a sieve pass runs: the mark memory is cleared, then scanned and
// marked; no input is taken until it ends.
// Per value: each table prime tried is fetched and divided on a single
// radix-2 divider (at least one division per prime); up to all 6542 table
// primes are tried. One value at a time; result held until taken.
// ----------------------------------------------------------------------------
// divisor_count_trial_division: top level
// Sieve sequencer, prime table, divider and count accumulator.
// ----------------------------------------------------------------------------
module divisor_count_trial_division (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [31:0] value_echo, [42:32] divisor_count, zero pad
);
  import dctd_pkg::*;

  state_t state, state_next;

  logic                marks [PRIME_LIMIT];
  logic [PRIME_W-1:0]  ptab  [PRIME_SLOTS];

  logic [MARK_AW:0]    n;
  logic [MARK_AW+1:0]  m;
  logic                mark_rd;
  logic [FOUND_W-1:0]  found;
  logic [FOUND_W-1:0]  k;
  logic [PRIME_W-1:0]  prime;
  logic [VALUE_W-1:0]  v;
  logic [VALUE_W-1:0]  value_in;
  logic [EXP_W-1:0]    e;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic [COUNT_W-1:0]  out_count;

  logic                div_start;
  logic                div_done;
  logic [VALUE_W-1:0]  quo;
  logic                rz;
  logic [COUNT_W-1:0]  count;
  logic                cnt_init, cnt_acc, cnt_dbl;

  dctd_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(v), .divisor(prime),
    .done(div_done), .quotient(quo), .rem_zero(rz)
  );

  dctd_mul u_mul (
    .clk(clk), .init(cnt_init), .acc(cnt_acc), .dbl(cnt_dbl),
    .exponent(e), .count(count)
  );

  logic [2*MARK_AW-1:0] sq;
  assign sq = n[MARK_AW-1:0] * n[MARK_AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (m == (MARK_AW+2)'(PRIME_LIMIT - 1)) state_next = ST_SCAN_RD;
      ST_SCAN_RD:  if (n >= (MARK_AW+1)'(PRIME_LIMIT)) state_next = ST_IDLE;
                   else state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: if (!mark_rd) state_next = ST_MARK;
                   else state_next = ST_SCAN_RD;
      ST_MARK:     if (m >= (MARK_AW+2)'(PRIME_LIMIT)) state_next = ST_SCAN_RD;
      ST_IDLE:     if (s_tvalid && !out_valid) state_next = ST_FETCH;
      ST_FETCH:    if (k >= found || v <= 32'd1) state_next = ST_OUT;
                   else state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_DIV;
      ST_DIV:      if (div_done) begin
                     if (rz) state_next = ST_LOAD;
                     else state_next = ST_ACC;
                   end
      ST_ACC:      state_next = ST_NEXT;
      ST_NEXT:     state_next = ST_FETCH;
      ST_OUT:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start  = (state == ST_LOAD);
    cnt_init   = (state == ST_IDLE);
    cnt_acc    = (state == ST_ACC);
    cnt_dbl    = 1'b0;
    s_tready   = (state == ST_IDLE) && !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      m         <= '0;
      n         <= (MARK_AW+1)'(2);
      found     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: m <= m + 1'b1;
        ST_SCAN_RD: ;
        ST_SCAN_CHK: begin
          if (!mark_rd) begin
            if (found < FOUND_W'(PRIME_SLOTS)) found <= found + 1'b1;
            if (sq >= (2*MARK_AW)'(PRIME_LIMIT)) m <= (MARK_AW+2)'(PRIME_LIMIT);
            else m <= sq[MARK_AW+1:0];
          end else begin
            n <= n + 1'b1;
          end
        end
        ST_MARK: begin
          if (m >= (MARK_AW+2)'(PRIME_LIMIT)) n <= n + 1'b1;
          else m <= m + (MARK_AW+2)'(n);
        end
        ST_IDLE: begin
          k <= '0;
          e <= '0;
          v <= s_tdata;
          value_in <= s_tdata;
        end
        ST_FETCH: e <= '0;
        ST_DIV: if (div_done && rz) begin
          v <= quo;
          e <= e + 1'b1;
        end
        ST_NEXT: k <= k + 1'b1;
        ST_OUT: begin
          out_valid <= 1'b1;
          out_value <= value_in;
          if (value_in == '0) out_count <= '0;
          else if (v > 32'd1) out_count <= {count[COUNT_W-2:0], 1'b0};
          else out_count <= count;
        end
        default: ;
      endcase
    end
  end

  // sieve mark memory and prime table
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) marks[m[MARK_AW-1:0]] <= 1'b0;
    else if (state == ST_MARK && m < (MARK_AW+2)'(PRIME_LIMIT))
      marks[m[MARK_AW-1:0]] <= 1'b1;
    mark_rd <= marks[n[MARK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN_CHK && !mark_rd && found < FOUND_W'(PRIME_SLOTS))
      ptab[found[SLOT_AW-1:0]] <= n[PRIME_W-1:0];
    prime <= ptab[k[SLOT_AW-1:0]];
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_count, out_value};

endmodule

// ===== rtl/dctd_checker.sv =====
// ----------------------------------------------------------------------------
// dctd_checker: port-level checks for the divisor counter
// Result stability under stall, plausible count values and no back-to-back accepts.
// ----------------------------------------------------------------------------
module dctd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");
  a_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:0] == 32'd1 |-> m_tdata[42:32] == 11'd1)
    else $error("count of one wrong");
  a_nz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:0] > 32'd1 |-> m_tdata[42:32] >= 11'd2)
    else $error("count too small");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted while busy");
endmodule

bind divisor_count_trial_division dctd_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/divisor_count_trial_division_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// divisor_count_trial_division_test: self-checking bench for the divisor counter
// Streams 32-bit values into the block and checks each echoed value and its
// divisor count against a typed count or a trial-division predictor. Directed
// extremes first, then mostly smooth random values with some full-range ones.
// Both sides idle at random, but for one stretch of random values.
// ----------------------------------------------------------------------------
module divisor_count_trial_division_test;
  import dctd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000000;
  localparam int RANDOM_ITEMS   = 82;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 typed;
    logic [COUNT_W-1:0] count;
  } row_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } divisor_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  divisor_result_t pending_counts[$];
  int  errors = 0;
  int  results_seen = 0;
  int  values_sent = 0;
  int  quiet_cycles = 0;
  bit  idling_on = 1'b1;
  row_t directed[$];

  divisor_count_trial_division dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // number of divisors by trial division over all integers up to the root
  function automatic logic [COUNT_W-1:0] count_divisors(logic [VALUE_W-1:0] v);
    longint unsigned rest;
    longint unsigned d;
    int unsigned     total;
    int unsigned     e;
    rest = v;
    total = 1;
    if (rest == 0) return '0;
    d = 2;
    while (d * d <= rest) begin
      e = 0;
      while (rest % d == 0) begin
        rest = rest / d;
        e++;
      end
      total = total * (e + 1);
      d++;
    end
    if (rest > 1) total = total * 2;
    return total[COUNT_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] smooth_value();
    int unsigned     small_primes[8] = '{2, 3, 5, 7, 11, 13, 17, 19};
    longint unsigned v;
    longint unsigned p;
    int              n;
    v = 1;
    n = $urandom_range(30, 1);
    for (int i = 0; i < n; i++) begin
      p = small_primes[$urandom_range(7, 0)];
      if (v * p <= 64'hFFFF_FFFF) v = v * p;
    end
    // occasionally one mid-size prime factor
    if ($urandom_range(3, 0) == 0 && v * 65521 <= 64'hFFFF_FFFF) v = v * 65521;
    return v[VALUE_W-1:0];
  endfunction

  task automatic send_value(logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] want);
    divisor_result_t entry;
    if (idling_on && $urandom_range(99, 0) < 27) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    entry.value = v;
    entry.count = want;
    pending_counts = {pending_counts, entry};
    values_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst) m_tready <= idling_on ? ($urandom_range(99, 0) >= 27) : 1'b1;
  end

  always @(posedge clk) begin
    divisor_result_t want;
    if (m_tvalid && m_tready && !rst) begin
      results_seen++;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result value=%0d count=%0d", $time,
                 m_tdata[31:0], m_tdata[42:32]);
        errors++;
      end else begin
        want = pending_counts.pop_front();
        if (m_tdata[31:0] !== want.value) begin
          $display("%0t: value_echo expected %0d got %0d", $time,
                   want.value, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[42:32] !== want.count) begin
          $display("%0t: divisor_count for %0d expected %0d got %0d", $time,
                   want.value, want.count, m_tdata[42:32]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_counts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] v;
    directed = '{
      '{32'd1,          1'b1, 11'd1},
      '{32'd0,          1'b1, 11'd0},    // zero gives the error count
      '{32'd2,          1'b1, 11'd2},
      '{32'hFFFF_FFFF,  1'b1, 11'd32},   // 3*5*17*257*65537
      '{32'hFFFF_FFFB,  1'b1, 11'd2},    // largest 32-bit prime
      '{32'h8000_0000,  1'b1, 11'd32},
      '{32'd65521,      1'b1, 11'd2},
      '{32'd65537,      1'b1, 11'd2},
      '{32'd4294836225, 1'b1, 11'd81},   // 65535 squared
      '{32'd735134400,  1'b1, 11'd1344}, // most divisors
      '{32'd3234846615, 1'b1, 11'd512},
      '{32'd4,          1'b0, 11'd0},
      '{32'd4294967294, 1'b0, 11'd0},
      '{32'h5555_5555,  1'b0, 11'd0},
      '{32'hAAAA_AAAA,  1'b0, 11'd0},
      '{32'h7FFF_FFFF,  1'b0, 11'd0},
      '{32'd4293001441, 1'b0, 11'd0},    // 65521 squared
      '{32'd65536,      1'b0, 11'd0}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      send_value(directed[i].value,
                 directed[i].typed ? directed[i].count : count_divisors(directed[i].value));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 30) begin
        s_tvalid <= 1'b0;
        wait (pending_counts.size() == 0);
        @(posedge clk);
      end
      idling_on = !(i >= 50 && i < 70);
      if ($urandom_range(99, 0) < 80) v = smooth_value();
      else begin
        v = $urandom();
        if (v == 0) v = 1;
      end
      send_value(v, count_divisors(v));
    end
    s_tvalid <= 1'b0;
    wait (pending_counts.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d values (directed extremes, smooth and full-range random),",
             values_sent);
    $display("checked %0d results with random idling on both sides.", results_seen);
    if (errors == 0 && pending_counts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dctd_pkg.sv
rtl/dctd_divider.sv
rtl/dctd_mul.sv
rtl/divisor_count_trial_division.sv
rtl/dctd_checker.sv
tb/divisor_count_trial_division_test.sv
